@@ rtl/lac_pkg.sv @@
// ----------------------------------------------------------------------------
// lac_pkg: shared types and helpers for the layer alpha compositor
// Field widths, sequencer states and the command and status records that
// pass between the top level and the blend engine.
// ----------------------------------------------------------------------------
package lac_pkg;

  localparam int PIX_W = 32;
  localparam int CH_W  = 8;
  localparam int DEN_W = 16;
  localparam int NUM_W = 24;
  localparam int DSR_W = NUM_W - 1;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'h00;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_sel_t;

  typedef enum logic [2:0] {
    BL_IDLE,
    BL_SETUP,
    BL_MUL_LO,
    BL_MUL_HI,
    BL_DIV_GO,
    BL_DIV_WAIT,
    BL_DONE
  } blend_state_t;

  typedef struct packed {
    logic             start;
    logic             ack;
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] lower;
  } blend_cmd_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [PIX_W-1:0] result;
  } blend_stat_t;

  function automatic logic [CH_W-1:0] chan_byte(input logic [PIX_W-1:0] pix,
                                                input chan_sel_t sel);
    logic [CH_W-1:0] b;
    case (sel)
      CH_RED:   b = pix[7:0];
      CH_GREEN: b = pix[15:8];
      CH_BLUE:  b = pix[23:16];
      default:  b = pix[7:0];
    endcase
    return b;
  endfunction

endpackage

@@ rtl/lac_if.sv @@
// ----------------------------------------------------------------------------
// lac_if: valid/ready channels of the layer alpha compositor
// One channel carries layer pixels in, the other composited pixels out.
// ----------------------------------------------------------------------------
interface lac_pix_if;
  import lac_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] layer_pixel;
  logic             first_layer;
  logic             last_layer;

  modport source (output valid, output layer_pixel, output first_layer,
                  output last_layer, input ready);
  modport sink   (input valid, input layer_pixel, input first_layer,
                  input last_layer, output ready);
endinterface

interface lac_res_if;
  import lac_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blended_pixel;

  modport source (output valid, output blended_pixel, input ready);
  modport sink   (input valid, input blended_pixel, output ready);
endinterface

@@ rtl/lac_div.sv @@
// ----------------------------------------------------------------------------
// lac_div: restoring divider with an 8-bit quotient
// One quotient bit per cycle; the dividend must be below 256 times the divisor.
// ----------------------------------------------------------------------------
module lac_div
  import lac_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [CH_W-1:0]  quotient
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [DSR_W-1:0] dsr_r, dsr_nxt;
  logic [CH_W-1:0]  q_r, q_nxt;
  logic             fits;

  assign fits = rem_r >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd0;
      rem_nxt  = dividend;
      dsr_nxt  = {divisor, 7'd0};
      q_nxt    = '0;
    end else if (busy_r) begin
      // Trial subtraction of the divisor aligned to the current bit.
      if (fits) begin
        rem_nxt = rem_r - {1'b0, dsr_r};
      end
      q_nxt   = {q_r[CH_W-2:0], fits};
      dsr_nxt = dsr_r >> 1;
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

@@ rtl/lac_blend.sv @@
// ----------------------------------------------------------------------------
// lac_blend: sequenced alpha-over blend of two partly transparent pixels
// One shared 8x16 multiplier builds the weights and each channel numerator,
// and one restoring divider yields the three channel quotients in turn.
// ----------------------------------------------------------------------------
module lac_blend
  import lac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  blend_cmd_t  cmd,
  output blend_stat_t stat
);

  blend_state_t     state_r, state_nxt;
  logic [PIX_W-1:0] upper_r, lower_r;
  logic [DEN_W-1:0] w0_r, den_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] res_r;
  chan_sel_t        ch_r;

  logic [CH_W-1:0]  a1, a0;
  logic [CH_W-1:0]  mul_a;
  logic [DEN_W-1:0] mul_b;
  logic [NUM_W-1:0] product;
  logic [DEN_W:0]   den_sum;
  logic             ld_pix, ld_setup, ld_lo, ld_hi, div_start;
  logic             div_done;
  logic [CH_W-1:0]  quotient;

  assign a1 = upper_r[31:24];
  assign a0 = lower_r[31:24];

  assign product = NUM_W'(mul_a) * NUM_W'(mul_b);
  assign den_sum = {1'b0, a1, 8'h00} + {1'b0, product[DEN_W-1:0]};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BL_IDLE:     if (cmd.start) state_nxt = BL_SETUP;
      BL_SETUP:    state_nxt = BL_MUL_LO;
      BL_MUL_LO:   state_nxt = BL_MUL_HI;
      BL_MUL_HI:   state_nxt = BL_DIV_GO;
      BL_DIV_GO:   state_nxt = BL_DIV_WAIT;
      BL_DIV_WAIT: begin
        if (div_done) state_nxt = (ch_r == CH_BLUE) ? BL_DONE : BL_MUL_LO;
      end
      BL_DONE:     if (cmd.ack) state_nxt = BL_IDLE;
      default:     state_nxt = BL_IDLE;
    endcase
  end

  always_comb begin
    ld_pix    = 1'b0;
    ld_setup  = 1'b0;
    ld_lo     = 1'b0;
    ld_hi     = 1'b0;
    div_start = 1'b0;
    mul_a     = a0;
    mul_b     = DEN_W'(9'd256 - {1'b0, a1});
    case (state_r)
      BL_IDLE:   ld_pix = cmd.start;
      BL_SETUP:  ld_setup = 1'b1;
      BL_MUL_LO: begin
        ld_lo = 1'b1;
        mul_a = chan_byte(lower_r, ch_r);
        mul_b = w0_r;
      end
      BL_MUL_HI: begin
        ld_hi = 1'b1;
        mul_a = chan_byte(upper_r, ch_r);
        mul_b = {8'h00, a1};
      end
      BL_DIV_GO: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BL_IDLE;
      ch_r    <= CH_RED;
    end else begin
      state_r <= state_nxt;
      if (ld_setup) begin
        ch_r <= CH_RED;
      end else if (state_r == BL_DIV_WAIT && div_done) begin
        case (ch_r)
          CH_RED:   ch_r <= CH_GREEN;
          CH_GREEN: ch_r <= CH_BLUE;
          default:  ch_r <= CH_RED;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_pix) begin
      upper_r <= cmd.upper;
      lower_r <= cmd.lower;
    end
    // Lower weight a0*(256-a1); den = 256*a1 + that weight.
    if (ld_setup) begin
      w0_r  <= product[DEN_W-1:0];
      den_r <= den_sum[DEN_W-1:0];
    end
    if (ld_lo) begin
      num_r <= product;
    end else if (ld_hi) begin
      num_r <= num_r + {product[DEN_W-1:0], 8'h00};
    end
    if (state_r == BL_DIV_WAIT && div_done) begin
      case (ch_r)
        CH_RED:   res_r[7:0]   <= quotient;
        CH_GREEN: res_r[15:8]  <= quotient;
        default:  res_r[23:16] <= quotient;
      endcase
    end
  end

  lac_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_r),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign stat.busy   = (state_r != BL_IDLE);
  assign stat.done   = (state_r == BL_DONE);
  assign stat.result = {den_r[15:8], res_r};

endmodule

@@ rtl/layer_alpha_compositor.sv @@
// ----------------------------------------------------------------------------
// layer_alpha_compositor: alpha-over compositing of a run of layer pixels
// Layer pixels arrive top layer first on in_chan; a beat with first_layer
// set loads the accumulator, later beats are merged beneath it, and a beat
// with last_layer set produces one composited pixel on out_chan.
// A first layer, an opaque accumulator, a clear layer pixel or a clear
// accumulator is settled in the accepting cycle, so such beats may follow
// one another every cycle while no blend is pending and the output slot is
// free. A layer that needs a real blend occupies the shared multiplier and
// restoring divider after its beat: a setup step, then per color channel a
// low and a high multiply step, a divider start and the quotient bits and
// hand-off, then a step to return the result. in_chan.ready stays low until
// that result is taken. The output is registered, so a composited pixel
// appears in the cycle after the last layer's beat, or after its blend
// result is taken. The output register lets a new beat be accepted in the
// cycle a waiting result is taken; if out_chan stalls, a finished blend that
// must be emitted is held in the engine and input is paused until the slot frees.
// Reset clears the accumulator to a fully transparent black pixel and
// empties the output register.
// ----------------------------------------------------------------------------
module layer_alpha_compositor
  import lac_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  lac_pix_if.sink   in_chan,
  lac_res_if.source out_chan
);

  logic [PIX_W-1:0] acc_r, acc_nxt;
  logic [PIX_W-1:0] out_pixel_r, out_pixel_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             pend_r, pend_nxt;
  logic             pend_last_r, pend_last_nxt;

  blend_cmd_t       cmd;
  blend_stat_t      stat;
  logic             in_fire, out_fire, slot_free;
  logic [PIX_W-1:0] pix;
  logic [CH_W-1:0]  acc_alpha, pix_alpha;

  assign pix       = in_chan.layer_pixel;
  assign acc_alpha = acc_r[31:24];
  assign pix_alpha = pix[31:24];

  assign out_fire  = out_valid_r && out_chan.ready;
  assign slot_free = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !pend_r && slot_free;
  assign in_fire   = in_chan.valid && in_chan.ready;

  always_comb begin
    acc_nxt       = acc_r;
    out_pixel_nxt = out_pixel_r;
    out_valid_nxt = out_valid_r && !out_fire;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    cmd.start     = 1'b0;
    cmd.ack       = 1'b0;
    cmd.upper     = acc_r;
    cmd.lower     = pix;

    if (in_fire) begin
      if (in_chan.first_layer || acc_alpha == ALPHA_CLEAR) begin
        // A first layer loads the pixel as is. A clear accumulator takes the lower
        // pixel as is unless that pixel is also clear; then the accumulator keeps
        // its own color bits, so the layer is skipped.
        acc_nxt = (in_chan.first_layer || pix_alpha != ALPHA_CLEAR) ? pix : acc_r;
      end else if (acc_alpha == ALPHA_OPAQUE || pix_alpha == ALPHA_CLEAR) begin
        acc_nxt = acc_r;
      end else begin
        cmd.start     = 1'b1;
        pend_nxt      = 1'b1;
        pend_last_nxt = in_chan.last_layer;
      end
      if (in_chan.last_layer && !cmd.start) begin
        out_valid_nxt = 1'b1;
        out_pixel_nxt = acc_nxt;
      end
    end else if (pend_r && stat.done && (!pend_last_r || slot_free)) begin
      cmd.ack  = 1'b1;
      acc_nxt  = stat.result;
      pend_nxt = 1'b0;
      if (pend_last_r) begin
        out_valid_nxt = 1'b1;
        out_pixel_nxt = stat.result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pixel_r <= out_pixel_nxt;
  end

  lac_blend u_blend (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  assign out_chan.valid         = out_valid_r;
  assign out_chan.blended_pixel = out_pixel_r;

  // The engine is only started when it is idle.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !stat.busy)
    else $error("blend started while engine busy");

  // No beat is taken while a blend is outstanding.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !in_chan.ready)
    else $error("input accepted during blend");

  // A result is only taken when the engine has one.
  a_ack_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ack |-> stat.done)
    else $error("blend result taken before done");

  // A blend of two non-clear pixels never yields a clear pixel.
  a_alpha_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> stat.result[31:24] != ALPHA_CLEAR)
    else $error("blend produced zero alpha");

endmodule

@@ sim/tb_layer_alpha_compositor.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_layer_alpha_compositor: self-checking bench for the layer compositor
// Layer beats go in with random gaps and composited pixels are taken with
// random stalls. A local alpha-over model predicts every emitted pixel,
// which is compared in order with what the block delivers.
// ----------------------------------------------------------------------------
module tb_layer_alpha_compositor;
  import lac_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_IDLE     = 13;
  localparam int RANDOM_ITEMS = 650;

  logic clk;
  logic rst_n;

  lac_pix_if layer_if ();
  lac_res_if result_if ();

  layer_alpha_compositor dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (layer_if),
    .out_chan (result_if)
  );

  logic [PIX_W-1:0] composite_acc;
  logic [PIX_W-1:0] expected_pixels[$];
  int               errors      = 0;
  int               reports     = 0;
  int               cycle_count = 0;
  int               stall_left  = 0;
  bit               quiet       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_layer_alpha_compositor NOT OK");
      $finish;
    end
  end

  // Alpha-over of one lower layer beneath the running composite.
  function automatic logic [PIX_W-1:0] merge_beneath(input logic [PIX_W-1:0] upper,
                                                     input logic [PIX_W-1:0] lower);
    logic [31:0]      a1;
    logic [31:0]      a0;
    logic [31:0]      den;
    logic [31:0]      c1;
    logic [31:0]      c0;
    logic [31:0]      num;
    logic [31:0]      quo;
    logic [PIX_W-1:0] merged;
    if (upper[31:24] == ALPHA_OPAQUE) return upper;
    if (lower[31:24] == ALPHA_CLEAR) return upper;
    if (upper[31:24] == ALPHA_CLEAR) return lower;
    a1  = {24'd0, upper[31:24]};
    a0  = {24'd0, lower[31:24]};
    den = ((a1 + a0) << 8) - a0 * a1;
    for (int i = 0; i < 3; i++) begin
      c1  = {24'd0, upper[8*i +: 8]};
      c0  = {24'd0, lower[8*i +: 8]};
      num = 32'd256 * c1 * a1 + c0 * a0 * (32'd256 - a1);
      quo = num / den;
      merged[8*i +: 8] = quo[7:0];
    end
    merged[31:24] = den[15:8];
    return merged;
  endfunction

  task automatic composite_layer(input logic [PIX_W-1:0] pix, input logic is_first,
                                 input logic is_last);
    if (is_first) composite_acc = pix;
    else composite_acc = merge_beneath(composite_acc, pix);
    if (is_last) expected_pixels = {expected_pixels, composite_acc};
  endtask

  task automatic send_layer(input logic [PIX_W-1:0] pix, input logic is_first,
                            input logic is_last);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      layer_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    layer_if.valid       <= 1'b1;
    layer_if.layer_pixel <= pix;
    layer_if.first_layer <= is_first;
    layer_if.last_layer  <= is_last;
    @(posedge clk);
    while (!layer_if.ready) @(posedge clk);
    composite_layer(pix, is_first, is_last);
  endtask

  // Alpha biased toward the clear and opaque values that take the short paths, and toward 1 and 254.
  function automatic logic [PIX_W-1:0] random_pixel();
    logic [7:0]  alpha;
    logic [31:0] bits;
    bits = $urandom();
    case ($urandom_range(0, 7))
      0:       alpha = ALPHA_CLEAR;
      1:       alpha = ALPHA_OPAQUE;
      2:       alpha = 8'd1;
      3:       alpha = 8'd254;
      default: alpha = bits[31:24] ^ 8'($urandom());
    endcase
    return {alpha, bits[23:0]};
  endfunction

  task automatic test_missing_first;
    // The accumulator is clear after reset, so both are transparent here.
    send_layer(32'h00123456, 1'b0, 1'b0);
    send_layer(32'h80AABBCC, 1'b0, 1'b1);
    // No first layer: this merges beneath the pixel just emitted.
    send_layer(32'hC0102030, 1'b0, 1'b1);
  endtask

  task automatic test_single_layer;
    send_layer(32'h00000000, 1'b1, 1'b1);
    send_layer(32'hFFFFFFFF, 1'b1, 1'b1);
    send_layer(32'h7F5A5AA5, 1'b1, 1'b1);
  endtask

  task automatic test_short_paths;
    send_layer(32'hFF010203, 1'b1, 1'b0);
    send_layer(32'h80FFFFFF, 1'b0, 1'b1);
    send_layer(32'h40123456, 1'b1, 1'b0);
    send_layer(32'h00FFFFFF, 1'b0, 1'b1);
    send_layer(32'h00ABCDEF, 1'b1, 1'b0);
    send_layer(32'h00112233, 1'b0, 1'b1);
    send_layer(32'h00FFFFFF, 1'b1, 1'b0);
    send_layer(32'hFF00FF00, 1'b0, 1'b1);
  endtask

  task automatic test_blend;
    send_layer(32'h01FFFFFF, 1'b1, 1'b0);
    send_layer(32'h01000000, 1'b0, 1'b1);
    send_layer(32'hFE00FF80, 1'b1, 1'b0);
    send_layer(32'hFFFF00FF, 1'b0, 1'b1);
    send_layer(32'h01000000, 1'b1, 1'b0);
    send_layer(32'hFFFFFFFF, 1'b0, 1'b1);
    send_layer(32'h80102030, 1'b1, 1'b0);
    send_layer(32'h40F0E0D0, 1'b0, 1'b0);
    send_layer(32'hFF0000FF, 1'b0, 1'b1);
  endtask

  // Mostly complete runs of random depth, with stray beats mixed in.
  task automatic test_random_runs(input int n_items);
    int sent;
    int depth;
    sent = 0;
    while (sent < n_items) begin
      if (sent % 50 < 5) quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 8) begin
        depth = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 5);
        for (int i = 0; i < depth; i++) begin
          send_layer(random_pixel(), i == 0, i == depth - 1);
        end
        sent += depth;
      end else begin
        send_layer(random_pixel(), 1'($urandom()), 1'($urandom()));
        sent++;
      end
    end
    quiet = 1'b0;
  endtask

  // Result side: a random stall follows each accepted result, except in quiet stretches.
  always @(posedge clk) begin : result_stall
    int stall;
    if (!rst_n) begin
      result_if.ready <= 1'b0;
      stall_left      <= 0;
    end else if (result_if.valid && result_if.ready) begin
      stall = quiet ? 0 : $urandom_range(0, MAX_IDLE);
      result_if.ready <= (stall == 0);
      stall_left      <= stall;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left      <= 0;
      result_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    logic [PIX_W-1:0] want;
    if (rst_n && result_if.valid && result_if.ready) begin
      if (expected_pixels.size() == 0) begin
        errors++;
        if (reports < 10) begin
          reports++;
          $display("unexpected blended pixel %08h", result_if.blended_pixel);
        end
      end else begin
        want = expected_pixels.pop_front();
        if (result_if.blended_pixel !== want) begin
          errors++;
          if (reports < 10) begin
            reports++;
            $display("blended pixel mismatch: expected %08h, got %08h",
                     want, result_if.blended_pixel);
          end
        end
      end
    end
  end

  initial begin
    rst_n                <= 1'b0;
    layer_if.valid       <= 1'b0;
    layer_if.layer_pixel <= '0;
    layer_if.first_layer <= 1'b0;
    layer_if.last_layer  <= 1'b0;
    composite_acc         = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_missing_first();
    test_single_layer();
    test_short_paths();
    test_blend();
    test_random_runs(RANDOM_ITEMS);

    layer_if.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("tb_layer_alpha_compositor OK");
    end else begin
      $display("tb_layer_alpha_compositor NOT OK");
    end
    $finish;
  end

endmodule
